// ===== rtl/srg_pkg.sv =====
// Shared types, constants and fixed-point helpers for the particle step pipeline.
package srg_pkg;

	localparam int WORD_W    = 32;
	localparam int NCOMP     = 3;
	localparam int AXIS_Y    = 1;
	localparam int FRAC      = 16;
	localparam int IN_W      = 4 * NCOMP * WORD_W;
	localparam int OUT_W     = 2 * NCOMP * WORD_W;
	localparam int SQ_W      = 2 * WORD_W;
	localparam int UNIT_NW   = WORD_W + FRAC;
	localparam int UNIT_QW   = FRAC + 2;
	localparam int CFG_IDX_W = 3;
	localparam int LAW_W     = 2;
	localparam int PARAM_W   = WORD_W - 1;

	localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
	localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef word_t [NCOMP-1:0] vec_t;
	typedef logic signed [UNIT_QW:0] unit_t;

	localparam word_t WORD_MAX = 32'sh7fff_ffff;
	localparam word_t WORD_MIN = 32'sh8000_0000;

	// fixed-point scale constants (0.1, 0.001, -0.01)
	localparam logic signed [15:0] SCALE_TREE       = 16'sd6554;
	localparam logic signed [15:0] SCALE_LEAF_REPEL = 16'sd66;
	localparam logic signed [15:0] SCALE_LEAF_GRAV  = -16'sd655;

	localparam logic [PARAM_W-1:0] MASS_RST = 31'd65536;
	localparam word_t              GRAV_RST = 32'sd65536;
	localparam logic [PARAM_W-1:0] DT_RST   = 31'd3277;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FORCE_LAW   = 3'd0,
		REG_MASS        = 3'd1,
		REG_CHARGE      = 3'd2,
		REG_REST_LEN    = 3'd3,
		REG_STIFFNESS   = 3'd4,
		REG_GRAVITY     = 3'd5,
		REG_TIME_STEP   = 3'd6
	} cfg_reg_t;

	typedef enum logic [LAW_W-1:0] {
		LAW_FULL = 2'd0,
		LAW_TREE = 2'd1,
		LAW_LEAF = 2'd2
	} law_t;

	function automatic logic signed [63:0] sx64(input word_t x);
		return {{32{x[WORD_W-1]}}, x};
	endfunction

	function automatic word_t sat32(input logic signed [63:0] x);
		word_t r;
		if (x > SAT_MAX) r = WORD_MAX;
		else if (x < SAT_MIN) r = WORD_MIN;
		else r = x[WORD_W-1:0];
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] mag32(input word_t x);
		logic [WORD_W-1:0] r;
		r = x[WORD_W-1] ? WORD_W'(-x) : WORD_W'(x);
		return r;
	endfunction

	// sat(floor(x * c / 65536))
	function automatic word_t scale(input word_t x, input logic signed [15:0] c);
		logic signed [63:0] p;
		p = sx64(x) * {{48{c[15]}}, c};
		return sat32(p >>> FRAC);
	endfunction

endpackage

// ===== rtl/srg_delay.sv =====
// Enabled shift line that carries a bundle of bits for a fixed number of stages.
module srg_delay #(
	parameter int W = srg_pkg::WORD_W,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);
	logic [W-1:0] line_s [N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) line_s[i] <= '0;
		end else if (en) begin
			line_s[0] <= din;
			for (int i = 1; i < N; i++) line_s[i] <= line_s[i-1];
		end
	end

	assign dout = line_s[N-1];

endmodule

// ===== rtl/srg_isqrt.sv =====
// Pipelined floor square root, one root bit per stage.
module srg_isqrt #(
	parameter int IN_W = srg_pkg::SQ_W
) (
	input  logic              clk,
	input  logic              en,
	input  logic [IN_W-1:0]   rad,
	output logic [IN_W/2-1:0] root
);
	localparam int RW  = IN_W / 2;
	localparam int RMW = RW + 3;

	logic [IN_W-1:0] rad_s  [1:RW-1];
	logic [RMW-1:0]  rem_s  [1:RW-1];
	logic [RW-1:0]   root_s [1:RW];

	for (genvar k = 0; k < RW; k++) begin : g_step
		logic [IN_W-1:0] rad_in;
		logic [RMW-1:0]  rem_in;
		logic [RW-1:0]   root_in;
		logic [RMW-1:0]  raw;
		logic [RMW-1:0]  test;
		logic            take;

		if (k == 0) begin : g_first
			assign rad_in  = rad;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign rad_in  = rad_s[k];
			assign rem_in  = rem_s[k];
			assign root_in = root_s[k];
		end

		// bring down the next bit pair and try root*4+1
		always_comb begin
			raw  = {rem_in[RMW-3:0], rad_in[IN_W-1-2*k -: 2]};
			test = RMW'({root_in, 2'b01});
			take = raw >= test;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k+1] <= {root_in[RW-2:0], take};
			end
		end

		if (k < RW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[k+1] <= rad_in;
					rem_s[k+1] <= take ? raw - test : raw;
				end
			end
		end
	end

	assign root = root_s[RW];

endmodule

// ===== rtl/srg_div.sv =====
// Pipelined unsigned restoring divider, one quotient bit per stage.
// The quotient must fit in Q_W bits; callers screen overflow themselves.
module srg_div #(
	parameter int NUM_W = srg_pkg::SQ_W,
	parameter int DEN_W = srg_pkg::SQ_W,
	parameter int Q_W   = srg_pkg::WORD_W
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quo
);
	localparam int CW = (NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W;

	logic [CW-1:0]    rem_s [1:Q_W-1];
	logic [DEN_W-1:0] den_s [1:Q_W-1];
	logic [Q_W-1:0]   quo_s [1:Q_W];

	for (genvar k = 0; k < Q_W; k++) begin : g_step
		localparam int B = Q_W - 1 - k;
		logic [CW-1:0]    rem_in;
		logic [DEN_W-1:0] den_in;
		logic [Q_W-1:0]   quo_in;
		logic [CW-1:0]    trial;
		logic             fits;

		if (k == 0) begin : g_first
			assign rem_in = CW'(num);
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[k];
			assign den_in = den_s[k];
			assign quo_in = quo_s[k];
		end

		// compare against the divisor shifted to this quotient bit
		always_comb begin
			trial = CW'(den_in) << B;
			fits  = trial <= rem_in;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[k+1] <= quo_in | (fits ? (Q_W'(1) << B) : '0);
			end
		end

		if (k < Q_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= fits ? rem_in - trial : rem_in;
					den_s[k+1] <= den_in;
				end
			end
		end
	end

	assign quo = quo_s[Q_W];

endmodule

// ===== rtl/spring_repel_gravity_euler_step_top.sv =====
// Top level: force summation and symplectic Euler step for one particle per word.
//
//  channel   direction  handshake                 payload (lowest bits first)
//  s_axis    in         s_axis_tvalid/tready      pos_x/y/z, vel_x/y/z, other_x/y/z, anchor_x/y/z
//  m_axis    out        m_axis_tvalid/tready      new_pos_x/y/z, new_vel_x/y/z
//  cfg       in         cfg_we (no back-pressure) cfg_index, cfg_data
//
// One word is accepted per cycle while the output word is not held. Words pass through
// the parallel 32-stage square root and repulsion quotient units, the 18-stage
// unit-vector dividers, the 32-stage acceleration divider and 14 arithmetic stages.
// Reset clears all valid bits and loads the register defaults.
// A held output word freezes the whole pipeline; nothing is dropped or repeated.
module spring_repel_gravity_euler_step_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [srg_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [srg_pkg::WORD_W-1:0]      cfg_data,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, other_x, other_y, other_z,
	// anchor_x, anchor_y, anchor_z; 32 bits each
	input  logic [srg_pkg::IN_W-1:0]        s_axis_tdata,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y, new_vel_z; 32 bits each
	output logic [srg_pkg::OUT_W-1:0]       m_axis_tdata
);
	import srg_pkg::*;

	localparam int VW = NCOMP * WORD_W;

	typedef struct packed {
		logic vld;
		logic zr;
		logic zs;
		logic big;
		vec_t dr;
		vec_t ds;
		vec_t p;
		vec_t v;
	} dly_a_t;

	typedef struct packed {
		logic              vld;
		logic              zr;
		logic              zs;
		logic              big;
		logic [NCOMP-1:0]  sgn_r;
		logic [NCOMP-1:0]  sgn_s;
		logic [WORD_W-1:0] rpl_q;
		logic [WORD_W-1:0] dist_s;
		vec_t              p;
		vec_t              v;
	} dly_b_t;

	typedef struct packed {
		logic             vld;
		logic [NCOMP-1:0] ovf;
		logic [NCOMP-1:0] sgn;
		vec_t             p;
		vec_t             v;
	} dly_c_t;

	// configuration registers
	logic [LAW_W-1:0]   force_law_q;
	logic [PARAM_W-1:0] mass_q;
	word_t              charge_q;
	logic [PARAM_W-1:0] rest_q;
	logic [PARAM_W-1:0] stiff_q;
	word_t              grav_q;
	logic [PARAM_W-1:0] dt_q;

	// gravity terms derived from the registers
	word_t              mg_q;
	word_t              grav_full_q;
	word_t              grav_leaf_q;
	logic signed [63:0] mg_prod;

	logic               en;
	logic               planar;
	logic [PARAM_W-1:0] mass_eff;
	logic [WORD_W-1:0]  charge_mag;

	// stage registers
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic vld_s10, vld_s11, vld_s12, vld_s13, vld_s14;

	vec_t dr_c, ds_c, pin, vin, oin, ain;
	vec_t dr_s1, ds_s1, p_s1, v_s1;
	vec_t dr_s2, ds_s2, p_s2, v_s2;
	logic [SQ_W-1:0] sq_r_s2 [NCOMP];
	logic [SQ_W-1:0] sq_s_s2 [NCOMP];
	vec_t dr_s3, ds_s3, p_s3, v_s3;
	logic [SQ_W-1:0] sr_s3, ss_s3;

	logic [SQ_W-1:0]   rpl_num;
	logic [WORD_W-1:0] dist_r, dist_s, rpl_quo;
	dly_a_t            a_in, a_out;

	logic [UNIT_NW-1:0] ur_num [NCOMP];
	logic [UNIT_NW-1:0] us_num [NCOMP];
	logic [UNIT_QW-1:0] ur_quo [NCOMP];
	logic [UNIT_QW-1:0] us_quo [NCOMP];
	logic [WORD_W-1:0]  den_r, den_s;
	dly_b_t             b_in, b_out;

	unit_t u_r_s4 [NCOMP];
	unit_t u_s_s4 [NCOMP];
	word_t m_s4, stretch_s4;
	logic  zr_s4, zs_s4;
	vec_t  p_s4, v_s4;

	logic signed [63:0] prod_r_s5 [NCOMP];
	unit_t              u_s_s5 [NCOMP];
	word_t              mag_s5;
	logic               zr_s5, zs_s5;
	vec_t               p_s5, v_s5;

	vec_t               fr_s6;
	logic signed [63:0] prod_s_s6 [NCOMP];
	logic               zs_s6;
	vec_t               p_s6, v_s6;

	vec_t fr_s7, fs_s7, p_s7, v_s7;
	vec_t full_s8, tree_r_s8, tree_s_s8, leaf_r_s8, fs_s8, p_s8, v_s8;
	vec_t f_c, f_s9, p_s9, v_s9;

	logic [UNIT_NW-1:0] acc_num [NCOMP];
	logic [WORD_W-1:0]  acc_quo [NCOMP];
	dly_c_t             c_in, c_out;

	vec_t               acc_s10, p_s10, v_s10;
	logic signed [63:0] pa_s11 [NCOMP];
	vec_t               p_s11, v_s11;
	vec_t               nv_s12, p_s12;
	logic signed [63:0] pb_s13 [NCOMP];
	vec_t               nv_s13, p_s13;
	vec_t               np_s14, nv_s14;

	logic signed [63:0] dt64;

	// configuration write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			force_law_q <= LAW_FULL;
			mass_q      <= MASS_RST;
			charge_q    <= '0;
			rest_q      <= '0;
			stiff_q     <= '0;
			grav_q      <= GRAV_RST;
			dt_q        <= DT_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FORCE_LAW: force_law_q <= cfg_data[LAW_W-1:0];
				REG_MASS:      mass_q      <= cfg_data[PARAM_W-1:0];
				REG_CHARGE:    charge_q    <= cfg_data;
				REG_REST_LEN:  rest_q      <= cfg_data[PARAM_W-1:0];
				REG_STIFFNESS: stiff_q     <= cfg_data[PARAM_W-1:0];
				REG_GRAVITY:   grav_q      <= cfg_data;
				REG_TIME_STEP: dt_q        <= cfg_data[PARAM_W-1:0];
				default: ;
			endcase
		end
	end

	// weight m*g and the two gravity force terms
	assign mg_prod = $signed({33'b0, mass_q}) * sx64(grav_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mg_q        <= GRAV_RST;
			grav_full_q <= -GRAV_RST;
			grav_leaf_q <= scale(GRAV_RST, SCALE_LEAF_GRAV);
		end else begin
			mg_q        <= sat32(mg_prod >>> FRAC);
			grav_full_q <= sat32(-sx64(mg_q));
			grav_leaf_q <= scale(mg_q, SCALE_LEAF_GRAV);
		end
	end

	assign planar     = force_law_q != LAW_FULL;
	assign mass_eff   = (mass_q == '0) ? PARAM_W'(1) : mass_q;
	assign charge_mag = mag32(charge_q);
	assign dt64       = $signed({33'b0, dt_q});

	// pipeline advances unless the output word is held
	assign en            = !vld_s14 || m_axis_tready;
	assign s_axis_tready = en;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0; vld_s2 <= 1'b0; vld_s3 <= 1'b0; vld_s4 <= 1'b0;
			vld_s5 <= 1'b0; vld_s6 <= 1'b0; vld_s7 <= 1'b0; vld_s8 <= 1'b0;
			vld_s9 <= 1'b0; vld_s10 <= 1'b0; vld_s11 <= 1'b0; vld_s12 <= 1'b0;
			vld_s13 <= 1'b0; vld_s14 <= 1'b0;
		end else if (en) begin
			vld_s1  <= s_axis_tvalid;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= b_out.vld;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= c_out.vld;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
		end
	end

	// s1: separations, y dropped for the planar laws
	always_comb begin
		pin = s_axis_tdata[0 +: VW];
		vin = s_axis_tdata[VW +: VW];
		oin = s_axis_tdata[2*VW +: VW];
		ain = s_axis_tdata[3*VW +: VW];
		for (int i = 0; i < NCOMP; i++) begin
			dr_c[i] = sat32(sx64(pin[i]) - sx64(oin[i]));
			ds_c[i] = sat32(sx64(ain[i]) - sx64(pin[i]));
		end
		if (planar) begin
			dr_c[AXIS_Y] = '0;
			ds_c[AXIS_Y] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dr_s1 <= dr_c;
			ds_s1 <= ds_c;
			p_s1  <= pin;
			v_s1  <= vin;
		end
	end

	// s2: squares
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NCOMP; i++) begin
				sq_r_s2[i] <= SQ_W'(sx64(dr_s1[i]) * sx64(dr_s1[i]));
				sq_s_s2[i] <= SQ_W'(sx64(ds_s1[i]) * sx64(ds_s1[i]));
			end
			dr_s2 <= dr_s1;
			ds_s2 <= ds_s1;
			p_s2  <= p_s1;
			v_s2  <= v_s1;
		end
	end

	// s3: squared lengths
	always_ff @(posedge clk) begin
		if (en) begin
			sr_s3 <= sq_r_s2[0] + sq_r_s2[1] + sq_r_s2[2];
			ss_s3 <= sq_s_s2[0] + sq_s_s2[1] + sq_s_s2[2];
			dr_s3 <= dr_s2;
			ds_s3 <= ds_s2;
			p_s3  <= p_s2;
			v_s3  <= v_s2;
		end
	end

	// lengths and repulsion quotient |q| * 2^32 / S
	assign rpl_num = {charge_mag, {WORD_W{1'b0}}};

	srg_isqrt #(.IN_W(SQ_W)) u_sqrt_r (
		.clk(clk), .en(en), .rad(sr_s3), .root(dist_r)
	);

	srg_isqrt #(.IN_W(SQ_W)) u_sqrt_s (
		.clk(clk), .en(en), .rad(ss_s3), .root(dist_s)
	);

	srg_div #(.NUM_W(SQ_W), .DEN_W(SQ_W), .Q_W(WORD_W)) u_div_rpl (
		.clk(clk), .en(en), .num(rpl_num), .den(sr_s3), .quo(rpl_quo)
	);

	always_comb begin
		a_in.vld = vld_s3;
		a_in.zr  = sr_s3 == '0;
		a_in.zs  = ss_s3 == '0;
		a_in.big = SQ_W'(charge_mag) >= sr_s3;
		a_in.dr  = dr_s3;
		a_in.ds  = ds_s3;
		a_in.p   = p_s3;
		a_in.v   = v_s3;
	end

	srg_delay #(.W($bits(dly_a_t)), .N(WORD_W)) u_dly_a (
		.clk(clk), .arst_n(arst_n), .en(en), .din(a_in), .dout(a_out)
	);

	// unit vectors d * 65536 / dist
	assign den_r = a_out.zr ? WORD_W'(1) : dist_r;
	assign den_s = a_out.zs ? WORD_W'(1) : dist_s;

	for (genvar i = 0; i < NCOMP; i++) begin : g_unit
		assign ur_num[i] = {mag32(a_out.dr[i]), {FRAC{1'b0}}};
		assign us_num[i] = {mag32(a_out.ds[i]), {FRAC{1'b0}}};

		srg_div #(.NUM_W(UNIT_NW), .DEN_W(WORD_W), .Q_W(UNIT_QW)) u_div_ur (
			.clk(clk), .en(en), .num(ur_num[i]), .den(den_r), .quo(ur_quo[i])
		);

		srg_div #(.NUM_W(UNIT_NW), .DEN_W(WORD_W), .Q_W(UNIT_QW)) u_div_us (
			.clk(clk), .en(en), .num(us_num[i]), .den(den_s), .quo(us_quo[i])
		);
	end

	always_comb begin
		b_in.vld    = a_out.vld;
		b_in.zr     = a_out.zr;
		b_in.zs     = a_out.zs;
		b_in.big    = a_out.big;
		for (int i = 0; i < NCOMP; i++) begin
			b_in.sgn_r[i] = a_out.dr[i][WORD_W-1];
			b_in.sgn_s[i] = a_out.ds[i][WORD_W-1];
		end
		b_in.rpl_q  = rpl_quo;
		b_in.dist_s = dist_s;
		b_in.p      = a_out.p;
		b_in.v      = a_out.v;
	end

	srg_delay #(.W($bits(dly_b_t)), .N(UNIT_QW)) u_dly_b (
		.clk(clk), .arst_n(arst_n), .en(en), .din(b_in), .dout(b_out)
	);

	// s4: signed unit vectors, repulsion magnitude, spring stretch
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NCOMP; i++) begin
				u_r_s4[i] <= b_out.sgn_r[i] ? -$signed({1'b0, ur_quo[i]})
				                            : $signed({1'b0, ur_quo[i]});
				u_s_s4[i] <= b_out.sgn_s[i] ? -$signed({1'b0, us_quo[i]})
				                            : $signed({1'b0, us_quo[i]});
			end
			if (charge_q[WORD_W-1]) begin
				m_s4 <= (b_out.big || b_out.rpl_q > WORD_W'(WORD_MIN)) ? WORD_MIN
				        : word_t'(-b_out.rpl_q);
			end else begin
				m_s4 <= (b_out.big || b_out.rpl_q[WORD_W-1]) ? WORD_MAX
				        : word_t'(b_out.rpl_q);
			end
			stretch_s4 <= sat32($signed({32'b0, b_out.dist_s}) - $signed({33'b0, rest_q}));
			zr_s4 <= b_out.zr;
			zs_s4 <= b_out.zs;
			p_s4  <= b_out.p;
			v_s4  <= b_out.v;
		end
	end

	// s5: repulsion products, spring magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NCOMP; i++) begin
				prod_r_s5[i] <= sx64(m_s4) * 64'(u_r_s4[i]);
				u_s_s5[i]    <= u_s_s4[i];
			end
			mag_s5 <= sat32(($signed({33'b0, stiff_q}) * sx64(stretch_s4)) >>> FRAC);
			zr_s5  <= zr_s4;
			zs_s5  <= zs_s4;
			p_s5   <= p_s4;
			v_s5   <= v_s4;
		end
	end

	// s6: repulsion force, spring products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NCOMP; i++) begin
				fr_s6[i]     <= zr_s5 ? '0 : sat32(prod_r_s5[i] >>> FRAC);
				prod_s_s6[i] <= sx64(mag_s5) * 64'(u_s_s5[i]);
			end
			zs_s6 <= zs_s5;
			p_s6  <= p_s5;
			v_s6  <= v_s5;
		end
	end

	// s7: spring force
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NCOMP; i++) begin
				fs_s7[i] <= zs_s6 ? '0 : sat32(prod_s_s6[i] >>> FRAC);
			end
			fr_s7 <= fr_s6;
			p_s7  <= p_s6;
			v_s7  <= v_s6;
		end
	end

	// s8: per-law partial terms
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NCOMP; i++) begin
				full_s8[i]   <= sat32(sx64((i == AXIS_Y) ? grav_full_q : '0) + sx64(fr_s7[i]));
				tree_r_s8[i] <= scale(fr_s7[i], SCALE_TREE);
				tree_s_s8[i] <= scale(fs_s7[i], SCALE_TREE);
				leaf_r_s8[i] <= scale(fr_s7[i], SCALE_LEAF_REPEL);
			end
			fs_s8 <= fs_s7;
			p_s8  <= p_s7;
			v_s8  <= v_s7;
		end
	end

	// s9: net force for the selected law
	always_comb begin
		for (int i = 0; i < NCOMP; i++) begin
			case (law_t'(force_law_q))
				LAW_FULL: f_c[i] = sat32(sx64(full_s8[i]) + sx64(fs_s8[i]));
				LAW_TREE: f_c[i] = sat32(sx64(tree_s_s8[i]) + sx64(tree_r_s8[i]));
				LAW_LEAF: f_c[i] = sat32(sx64((i == AXIS_Y) ? grav_leaf_q : '0)
				                         + sx64(leaf_r_s8[i]));
				default:  f_c[i] = '0;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			f_s9 <= f_c;
			p_s9 <= p_s8;
			v_s9 <= v_s8;
		end
	end

	// acceleration F * 65536 / mass
	for (genvar i = 0; i < NCOMP; i++) begin : g_acc
		assign acc_num[i] = {mag32(f_s9[i]), {FRAC{1'b0}}};

		srg_div #(.NUM_W(UNIT_NW), .DEN_W(PARAM_W), .Q_W(WORD_W)) u_div_acc (
			.clk(clk), .en(en), .num(acc_num[i]), .den(mass_eff), .quo(acc_quo[i])
		);
	end

	always_comb begin
		c_in.vld = vld_s9;
		for (int i = 0; i < NCOMP; i++) begin
			c_in.ovf[i] = PARAM_W'(mag32(f_s9[i]) >> FRAC) >= mass_eff;
			c_in.sgn[i] = f_s9[i][WORD_W-1];
		end
		c_in.p = p_s9;
		c_in.v = v_s9;
	end

	srg_delay #(.W($bits(dly_c_t)), .N(WORD_W)) u_dly_c (
		.clk(clk), .arst_n(arst_n), .en(en), .din(c_in), .dout(c_out)
	);

	// s10: saturated acceleration
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NCOMP; i++) begin
				if (c_out.ovf[i]) acc_s10[i] <= c_out.sgn[i] ? WORD_MIN : WORD_MAX;
				else if (c_out.sgn[i]) acc_s10[i] <= sat32(-$signed({32'b0, acc_quo[i]}));
				else acc_s10[i] <= sat32($signed({32'b0, acc_quo[i]}));
			end
			p_s10 <= c_out.p;
			v_s10 <= c_out.v;
		end
	end

	// s11: a * dt
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NCOMP; i++) pa_s11[i] <= sx64(acc_s10[i]) * dt64;
			p_s11 <= p_s10;
			v_s11 <= v_s10;
		end
	end

	// s12: new velocity
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NCOMP; i++) begin
				nv_s12[i] <= sat32(sx64(v_s11[i]) + (pa_s11[i] >>> FRAC));
			end
			p_s12 <= p_s11;
		end
	end

	// s13: v' * dt
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NCOMP; i++) pb_s13[i] <= sx64(nv_s12[i]) * dt64;
			nv_s13 <= nv_s12;
			p_s13  <= p_s12;
		end
	end

	// s14: new position, output register
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < NCOMP; i++) begin
				np_s14[i] <= sat32(sx64(p_s13[i]) + (pb_s13[i] >>> FRAC));
			end
			nv_s14 <= nv_s13;
		end
	end

	assign m_axis_tvalid = vld_s14;
	assign m_axis_tdata  = {nv_s14, np_s14};

endmodule
